### rtl/core/lcks_pkg.sv
// Shared types, key codes and the LED pattern table for the LED chaser
// key/speed control block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcks_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_KEY  = 1'b1
  } lcks_op_t;

  // Key codes, upper-nibble form (active low, bit i = key i)
  localparam logic [3:0] KEY_CLEAR   = 4'h0;
  localparam logic [3:0] KEY_NONE    = 4'hF;
  localparam logic [3:0] KEY_RIGHT   = 4'hE;
  localparam logic [3:0] KEY_LEFT    = 4'hD;
  localparam logic [3:0] KEY_SHORTER = 4'hB;
  localparam logic [3:0] KEY_LONGER  = 4'h7;

  localparam logic [7:0]  LED_RESET    = 8'hFF;
  localparam logic [15:0] PERIOD_RESET = 16'd1;

  typedef struct packed {
    lcks_op_t   opcode;
    logic [3:0] key_bits;
  } lcks_item_t;

  typedef struct packed {
    logic [7:0]  led_pattern;
    logic        step_fired;
    logic [15:0] step_period;
  } lcks_res_t;

  typedef struct packed {
    logic       valid;
    lcks_item_t item;
  } lcks_stg_t;

  function automatic logic [7:0] led_pattern(input logic rot_right, input logic [1:0] ph);
    logic [7:0] pat;
    unique case (ph)
      2'd0: pat = 8'h30;
      2'd1: pat = rot_right ? 8'h90 : 8'h60;
      2'd2: pat = 8'hC0;
      2'd3: pat = rot_right ? 8'h60 : 8'h90;
      default: pat = 8'h30;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lcks_if.sv
// Valid/ready channel interfaces for input words and result words.
// Depends on lcks_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lcks_in_if;
  logic                valid;
  logic                ready;
  lcks_pkg::lcks_op_t  opcode;
  logic [3:0]          key_bits;

  modport source (output valid, output opcode, output key_bits, input ready);
  modport sink   (input valid, input opcode, input key_bits, output ready);
endinterface

interface lcks_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  led_pattern;
  logic        step_fired;
  logic [15:0] step_period;

  modport source (output valid, output led_pattern, output step_fired, output step_period,
                  input ready);
  modport sink   (input valid, input led_pattern, input step_fired, input step_period,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/lcks_in_reg.sv
// Input register stage: captures one word, releases it when the update
// stage takes it. Depends on lcks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcks_in_reg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire lcks_pkg::lcks_item_t  in_item,
  output logic                       in_ready,
  input  wire logic                  take,
  output lcks_pkg::lcks_stg_t        stg
);

  logic                 valid_r, valid_nxt;
  lcks_pkg::lcks_item_t item_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stg.valid = valid_r;
  assign stg.item  = item_r;

endmodule

`default_nettype wire

### rtl/core/lcks_update.sv
// Chaser state registers and single-pass update for one tick or key word.
// Depends on lcks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcks_update (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire lcks_pkg::lcks_item_t  item,
  output lcks_pkg::lcks_res_t        res
);

  logic [15:0] tick_r, tick_nxt;
  logic [15:0] period_r, period_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        rot_r, rot_nxt;
  logic [3:0]  last_key_r, last_key_nxt;
  logic [7:0]  led_r, led_nxt;
  logic [15:0] tick_inc;
  logic [15:0] period_eff;
  logic [1:0]  phase_inc;
  logic        fired;

  always_comb begin
    tick_inc     = tick_r + 16'd1;
    period_eff   = (period_r == 16'd0) ? 16'd1 : period_r;
    phase_inc    = phase_r + 2'd1;
    tick_nxt     = tick_r;
    period_nxt   = period_r;
    phase_nxt    = phase_r;
    rot_nxt      = rot_r;
    last_key_nxt = last_key_r;
    led_nxt      = led_r;
    fired        = 1'b0;
    if (item.opcode == lcks_pkg::OP_TICK) begin
      period_nxt = period_eff;
      if (tick_inc == period_eff) begin
        tick_nxt  = 16'd0;
        phase_nxt = phase_inc;
        led_nxt   = lcks_pkg::led_pattern(rot_r, phase_inc);
        fired     = 1'b1;
      end else begin
        tick_nxt = tick_inc;
      end
    end else if (item.key_bits == lcks_pkg::KEY_NONE) begin
      last_key_nxt = lcks_pkg::KEY_CLEAR;
    end else if (item.key_bits != last_key_r) begin
      last_key_nxt = item.key_bits;
      unique case (item.key_bits)
        lcks_pkg::KEY_RIGHT: rot_nxt = 1'b1;
        lcks_pkg::KEY_LEFT:  rot_nxt = 1'b0;
        lcks_pkg::KEY_SHORTER: begin
          period_nxt = period_r - 16'd1;
          tick_nxt   = 16'd0;
        end
        lcks_pkg::KEY_LONGER: begin
          period_nxt = period_r + 16'd1;
          tick_nxt   = 16'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= 16'd0;
      period_r   <= lcks_pkg::PERIOD_RESET;
      phase_r    <= 2'd0;
      rot_r      <= 1'b0;
      last_key_r <= lcks_pkg::KEY_CLEAR;
      led_r      <= lcks_pkg::LED_RESET;
    end else if (en) begin
      tick_r     <= tick_nxt;
      period_r   <= period_nxt;
      phase_r    <= phase_nxt;
      rot_r      <= rot_nxt;
      last_key_r <= last_key_nxt;
      led_r      <= led_nxt;
    end
  end

  assign res.led_pattern = led_nxt;
  assign res.step_fired  = fired;
  assign res.step_period = period_nxt;

  a_fire_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (en && fired) |-> (item.opcode == lcks_pkg::OP_TICK))
    else $error("step fired on a key word");

  a_fire_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (en && fired) |=> (tick_r == 16'd0))
    else $error("tick count not cleared after a step");

  a_tick_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && item.opcode == lcks_pkg::OP_TICK) |=> (period_r != 16'd0))
    else $error("zero period survived a tick");

  a_key_leaves_led: assert property (@(posedge clk) disable iff (!rst_n)
    (en && item.opcode == lcks_pkg::OP_KEY) |=> $stable(led_r))
    else $error("key word changed the LED byte");

endmodule

`default_nettype wire

### rtl/core/lcks_out_reg.sv
// Result register: holds one result word until the sink takes it.
// Depends on lcks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcks_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire lcks_pkg::lcks_res_t  res,
  output logic                      free,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lcks_pkg::lcks_res_t       out_res
);

  logic                valid_r, valid_nxt;
  lcks_pkg::lcks_res_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

### rtl/core/led_chaser_key_speed_control_unit.sv
// Top level of the LED chaser with key speed and direction control.
// Depends on lcks_pkg, lcks_if, lcks_in_reg, lcks_update, lcks_out_reg.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    opcode, key_bits
//   out_ch   out  valid/ready    led_pattern, step_fired, step_period
//
// One word per cycle sustained while out_ch is ready; an accepted word goes into the
// input register, then through the update into the result register, before out_ch shows it.
// Reset (sync, rst_n low) empties both stages and restores period 1, LED 0xFF.
// With out_ch stalled the result register holds; the input register still
// takes one more word, then in_ch.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module led_chaser_key_speed_control_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lcks_in_if.sink    in_ch,
  lcks_out_if.source out_ch
);

  lcks_pkg::lcks_item_t in_item;
  lcks_pkg::lcks_stg_t  stg;
  lcks_pkg::lcks_res_t  res;
  lcks_pkg::lcks_res_t  out_res;
  logic                 out_free;
  logic                 advance;
  logic                 in_ready;
  logic                 out_valid;

  assign in_item.opcode   = in_ch.opcode;
  assign in_item.key_bits = in_ch.key_bits;
  assign in_ch.ready      = in_ready;
  assign advance          = stg.valid && out_free;

  lcks_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ready),
    .take     (advance),
    .stg      (stg)
  );

  lcks_update u_update (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (stg.item),
    .res   (res)
  );

  lcks_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.led_pattern = out_res.led_pattern;
  assign out_ch.step_fired  = out_res.step_fired;
  assign out_ch.step_period = out_res.step_period;

endmodule

`default_nettype wire

### tb/sv/lcks_chaser_checker.sv
// Scoreboard for the LED chaser block: watches both channels, predicts each
// result word from the accepted input words and compares in order.
// Depends on lcks_pkg and lcks_if.
`timescale 1ns / 1ps

module lcks_chaser_checker (
  input  logic clk,
  input  logic rst_n,
  lcks_in_if   in_ch,
  lcks_out_if  out_ch,
  output int   fail_count,
  output int   words_pending
);

  logic [15:0] tick_cnt;
  logic [15:0] period;
  logic [1:0]  phase;
  logic        rot_right;
  logic [7:0]  held_key;
  logic [7:0]  led_byte;

  lcks_pkg::lcks_res_t predicted_outputs[$];
  lcks_pkg::lcks_res_t want;
  lcks_pkg::lcks_res_t next_res;

  function automatic logic [7:0] chase_pattern(input logic rr, input logic [1:0] ph);
    case ({rr, ph})
      3'b000, 3'b100: return 8'h30;
      3'b001, 3'b111: return 8'h60;
      3'b010, 3'b110: return 8'hC0;
      default:        return 8'h90;
    endcase
  endfunction

  task automatic advance_chaser(input lcks_pkg::lcks_op_t op, input logic [3:0] keys,
                                output lcks_pkg::lcks_res_t res);
    logic [7:0] key_byte;
    key_byte = {keys, 4'h0};
    res.step_fired = 1'b0;
    if (op == lcks_pkg::OP_TICK) begin
      tick_cnt = tick_cnt + 16'd1;
      if (period == 16'd0) period = 16'd1;
      if (tick_cnt == period) begin
        tick_cnt = 16'd0;
        phase = phase + 2'd1;
        led_byte = chase_pattern(rot_right, phase);
        res.step_fired = 1'b1;
      end
    end else if (keys == lcks_pkg::KEY_NONE) begin
      held_key = 8'h00;
    end else if (key_byte != held_key) begin
      held_key = key_byte;
      case (keys)
        lcks_pkg::KEY_RIGHT: rot_right = 1'b1;
        lcks_pkg::KEY_LEFT: rot_right = 1'b0;
        lcks_pkg::KEY_SHORTER: begin
          period = period - 16'd1;
          tick_cnt = 16'd0;
        end
        lcks_pkg::KEY_LONGER: begin
          period = period + 16'd1;
          tick_cnt = 16'd0;
        end
        default: ;
      endcase
    end
    res.led_pattern = led_byte;
    res.step_period = period;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt = 16'd0;
      period = lcks_pkg::PERIOD_RESET;
      phase = 2'd0;
      rot_right = 1'b0;
      held_key = 8'h00;
      led_byte = lcks_pkg::LED_RESET;
      predicted_outputs.delete();
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_chaser(in_ch.opcode, in_ch.key_bits, next_res);
        predicted_outputs.push_back(next_res);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_outputs.size() == 0) begin
          $error("unexpected result word: led_pattern %h step_fired %b step_period %0d",
                 out_ch.led_pattern, out_ch.step_fired, out_ch.step_period);
          fail_count++;
        end else begin
          want = predicted_outputs.pop_front();
          if (out_ch.led_pattern !== want.led_pattern) begin
            $error("led_pattern: expected %h, got %h", want.led_pattern, out_ch.led_pattern);
            fail_count++;
          end
          if (out_ch.step_fired !== want.step_fired) begin
            $error("step_fired: expected %b, got %b", want.step_fired, out_ch.step_fired);
            fail_count++;
          end
          if (out_ch.step_period !== want.step_period) begin
            $error("step_period: expected %0d, got %0d", want.step_period, out_ch.step_period);
            fail_count++;
          end
        end
      end
    end
    words_pending = predicted_outputs.size();
  end

endmodule

### tb/sv/tb_led_chaser_key_speed_control_unit.sv
// Top of the LED chaser testbench: clock, reset, bursty input words, a
// stalling result sink, a no-progress watchdog and the verdict.
// Depends on lcks_pkg, lcks_if, the block and lcks_chaser_checker.
`timescale 1ns / 1ps

module tb_led_chaser_key_speed_control_unit;

  localparam int NUM_RANDOM  = 1200;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_THREE_OF_FOUR,
    RX_SPARSE
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic rx_ready = 1'b0;
  logic in_taken = 1'b0;
  int   idle_cycles = 0;
  int   rx_cycle = 0;
  rx_mode_t rx_mode = RX_OPEN;

  int fail_count;
  int words_pending;
  int burst_left;
  logic [3:0]  held;
  logic [15:0] est_period;

  lcks_in_if  in_ch ();
  lcks_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  led_chaser_key_speed_control_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lcks_chaser_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** led_chaser_key_speed_control_unit: FAILED **");
        $finish;
      end
    end
  end

  // sink stall pattern, re-picked at random from the four modes
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: rx_ready <= 1'b1;
      RX_COIN: rx_ready <= 1'($urandom_range(0, 1));
      RX_THREE_OF_FOUR: rx_ready <= (rx_cycle % 4) != 0;
      default: rx_ready <= (rx_cycle % 8) == 0;
    endcase
  end

  // drive one word, wait for its handshake, then pace the next one
  task automatic issue_word(input lcks_pkg::lcks_op_t op, input logic [3:0] keys);
    int gap;
    in_ch.valid = 1'b1;
    in_ch.opcode = op;
    in_ch.key_bits = keys;
    do @(negedge clk); while (!in_taken);
    if (op == lcks_pkg::OP_KEY) begin
      if (keys == lcks_pkg::KEY_NONE) begin
        held = lcks_pkg::KEY_NONE;
      end else if (keys != held) begin
        if (keys == lcks_pkg::KEY_SHORTER) est_period = est_period - 16'd1;
        if (keys == lcks_pkg::KEY_LONGER) est_period = est_period + 16'd1;
        held = keys;
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  initial begin
    int roll;
    logic [3:0] press;
    in_ch.valid = 1'b0;
    in_ch.opcode = lcks_pkg::OP_TICK;
    in_ch.key_bits = 4'h0;
    held = lcks_pkg::KEY_CLEAR;
    est_period = lcks_pkg::PERIOD_RESET;
    burst_left = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // period 1: every tick steps, left rotation
    issue_word(lcks_pkg::OP_TICK, 4'h0);
    issue_word(lcks_pkg::OP_TICK, 4'hF);
    issue_word(lcks_pkg::OP_TICK, 4'hA);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_RIGHT);
    issue_word(lcks_pkg::OP_TICK, 4'h5);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_RIGHT);   // held, no effect
    issue_word(lcks_pkg::OP_TICK, 4'h0);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_NONE);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_LEFT);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_NONE);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_LONGER);
    issue_word(lcks_pkg::OP_TICK, 4'h0);
    issue_word(lcks_pkg::OP_TICK, 4'h0);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_NONE);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_SHORTER);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_NONE);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_SHORTER); // zero period
    issue_word(lcks_pkg::OP_TICK, 4'h0);                 // forced back to 1
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_NONE);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_SHORTER);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_NONE);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_SHORTER); // wraps to 0xFFFF
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_NONE);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_LONGER);  // wraps to 0
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_CLEAR);   // multi-key, stored only
    issue_word(lcks_pkg::OP_KEY, 4'b1100);
    issue_word(lcks_pkg::OP_TICK, 4'hF);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_NONE);
    issue_word(lcks_pkg::OP_KEY, lcks_pkg::KEY_LONGER);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        issue_word(lcks_pkg::OP_TICK, 4'($urandom_range(0, 15)));
      end else if (roll < 65) begin
        issue_word(lcks_pkg::OP_KEY, 4'($urandom_range(0, 15)));
      end else if (held != lcks_pkg::KEY_NONE) begin
        issue_word(lcks_pkg::OP_KEY,
                   ($urandom_range(0, 4) == 0) ? held : lcks_pkg::KEY_NONE);
      end else begin
        case ($urandom_range(0, 3))
          0: press = lcks_pkg::KEY_RIGHT;
          1: press = lcks_pkg::KEY_LEFT;
          default: begin
            if (est_period > 16'd5 && est_period != 16'hFFFF) begin
              press = lcks_pkg::KEY_SHORTER;
            end else if (est_period < 16'd2 || est_period == 16'hFFFF) begin
              press = lcks_pkg::KEY_LONGER;
            end else begin
              press = $urandom_range(0, 1) ? lcks_pkg::KEY_SHORTER : lcks_pkg::KEY_LONGER;
            end
          end
        endcase
        issue_word(lcks_pkg::OP_KEY, press);
      end
    end

    in_ch.valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("** led_chaser_key_speed_control_unit: PASSED **");
    end else begin
      $display("** led_chaser_key_speed_control_unit: FAILED **");
    end
    $finish;
  end

endmodule
